// ===== design/mse_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the MIPS subset executor.
// No dependencies; every other design file but mse_ram refers to this package by scoped names.
package mse_pkg;

    localparam int unsigned REG_COUNT  = 32;
    localparam int unsigned REG_ADDR_W = 5;
    localparam int unsigned WORD_W     = 32;
    localparam int unsigned LEN_W      = 9;

    localparam logic [WORD_W-1:0] RESET_PC = 32'h0040_0000;

    // Primary opcodes (instruction bits 31..26).
    localparam logic [5:0] OP_SPECIAL = 6'h00;
    localparam logic [5:0] OP_BEQ     = 6'h04;
    localparam logic [5:0] OP_BNE     = 6'h05;
    localparam logic [5:0] OP_ADDI    = 6'h08;
    localparam logic [5:0] OP_ANDI    = 6'h0C;

    // Function codes of the special opcode (instruction bits 5..0).
    localparam logic [5:0] FN_SLL = 6'h00;
    localparam logic [5:0] FN_SRL = 6'h02;
    localparam logic [5:0] FN_ADD = 6'h20;

    // Configuration register indexes.
    localparam logic CFG_START_ADDRESS  = 1'b0;
    localparam logic CFG_PROGRAM_LENGTH = 1'b1;

    typedef enum logic [3:0] {
        UOP_READ,
        UOP_ADD,
        UOP_ADDI,
        UOP_ANDI,
        UOP_SLL,
        UOP_SRL,
        UOP_BEQ,
        UOP_BNE,
        UOP_ILLEGAL
    } uop_kind_t;

    // One classified beat as it travels from the front end to the back end.
    typedef struct packed {
        uop_kind_t             kind;
        logic [REG_ADDR_W-1:0] rs;
        logic [REG_ADDR_W-1:0] rt;
        logic [REG_ADDR_W-1:0] dest;
        logic [4:0]            shamt;
        logic [15:0]           imm;
    } uop_t;

    // One result beat.
    typedef struct packed {
        logic [WORD_W-1:0]     next_pc;
        logic                  reg_write;
        logic [REG_ADDR_W-1:0] write_reg;
        logic [WORD_W-1:0]     write_value;
        logic                  branch_taken;
        logic                  illegal;
        logic                  past_end;
        logic [WORD_W-1:0]     read_value;
    } result_t;

endpackage

// ===== design/mse_ram.sv =====
`timescale 1ns / 1ps
// Generic RAM: one write port, two read ports with registered read data.
// No dependencies.
module mse_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_a,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_a <= mem_reg[raddr_a];
            rdata_b <= mem_reg[raddr_b];
        end
    end

endmodule

// ===== design/mse_front.sv =====
`timescale 1ns / 1ps
// Front end: classifies each incoming beat into a decoded micro-op.
// Depends on mse_pkg.
module mse_front (
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic                           action,
    input  logic [31:0]                    instr,
    input  logic [mse_pkg::REG_ADDR_W-1:0] reg_index,
    output logic                           push_valid,
    input  logic                           push_ready,
    output mse_pkg::uop_t                  push_uop
);

    logic [5:0] opcode;
    logic [5:0] funct;

    assign opcode     = instr[31:26];
    assign funct      = instr[5:0];
    assign push_valid = in_valid;
    assign in_ready   = push_ready;

    always_comb
    begin
        push_uop.rs    = instr[25:21];
        push_uop.rt    = instr[20:16];
        push_uop.dest  = instr[20:16];
        push_uop.shamt = instr[10:6];
        push_uop.imm   = instr[15:0];
        push_uop.kind  = mse_pkg::UOP_ILLEGAL;
        if (action)
        begin
            // A register read reuses the first read port.
            push_uop.kind = mse_pkg::UOP_READ;
            push_uop.rs   = reg_index;
        end
        else
        begin
            unique case (opcode)
                mse_pkg::OP_SPECIAL:
                begin
                    push_uop.dest = instr[15:11];
                    unique case (funct)
                        mse_pkg::FN_ADD: push_uop.kind = mse_pkg::UOP_ADD;
                        mse_pkg::FN_SLL: push_uop.kind = mse_pkg::UOP_SLL;
                        mse_pkg::FN_SRL: push_uop.kind = mse_pkg::UOP_SRL;
                        default:         push_uop.kind = mse_pkg::UOP_ILLEGAL;
                    endcase
                end
                mse_pkg::OP_ADDI: push_uop.kind = mse_pkg::UOP_ADDI;
                mse_pkg::OP_ANDI: push_uop.kind = mse_pkg::UOP_ANDI;
                mse_pkg::OP_BEQ:  push_uop.kind = mse_pkg::UOP_BEQ;
                mse_pkg::OP_BNE:  push_uop.kind = mse_pkg::UOP_BNE;
                default:          push_uop.kind = mse_pkg::UOP_ILLEGAL;
            endcase
        end
    end

endmodule

// ===== design/mse_queue.sv =====
`timescale 1ns / 1ps
// Small FIFO of decoded micro-ops between the front end and the back end.
// Depends on mse_pkg. DEPTH must be a power of two, at least 2.
module mse_queue #(
    parameter int unsigned DEPTH = 2
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push_valid,
    output logic          push_ready,
    input  mse_pkg::uop_t push_uop,
    output logic          pop_valid,
    input  logic          pop_ready,
    output mse_pkg::uop_t pop_uop
);

    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    mse_pkg::uop_t    slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_uop    = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_uop;
        end
    end

endmodule

// ===== design/mse_back.sv =====
`timescale 1ns / 1ps
// Back end: register file read, execute, register file and pc update, output register.
// Depends on mse_pkg and mse_ram; also holds the two configuration registers.
module mse_back #(
    parameter int unsigned PROGRAM_WORDS = 256
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 q_valid,
    output logic                 q_ready,
    input  mse_pkg::uop_t        q_uop,
    input  logic                 cfg_write,
    input  logic                 cfg_index,
    input  logic [31:0]          cfg_data,
    output logic                 res_valid,
    input  logic                 res_ready,
    output mse_pkg::result_t     res
);

    localparam int unsigned AW = mse_pkg::REG_ADDR_W;
    localparam int unsigned LW = mse_pkg::LEN_W;

    // Issue stage to execute stage.
    logic          issue;
    logic          x_fire;
    logic          x_valid_reg;
    logic          x_valid_next;
    mse_pkg::uop_t x_uop_reg;
    logic          a_byp_reg;
    logic          a_byp_next;
    logic          b_byp_reg;
    logic          b_byp_next;
    logic          a_ok_reg;
    logic          b_ok_reg;
    logic [31:0]   byp_val_reg;

    logic [mse_pkg::REG_COUNT-1:0] written_reg;
    logic [mse_pkg::REG_COUNT-1:0] written_next;

    logic [31:0]   pc_reg;
    logic [31:0]   pc_next;
    logic [31:0]   start_reg;
    logic [31:0]   start_next;
    logic [LW-1:0] length_reg;
    logic [LW-1:0] length_next;

    logic             out_valid_reg;
    logic             out_valid_next;
    mse_pkg::result_t out_res_reg;

    logic [31:0]   ram_a;
    logic [31:0]   ram_b;
    logic [31:0]   op_a;
    logic [31:0]   op_b;
    logic [31:0]   simm;
    logic [31:0]   pc_plus4;
    logic [31:0]   x_val;
    logic [31:0]   x_npc;
    logic          x_wr_kind;
    logic          x_wr;
    logic          x_taken;
    logic          x_bad;
    logic          x_read;
    logic          ops_equal;
    logic [LW-1:0] length_eff;
    logic [32:0]   end_addr;
    logic          x_past;
    mse_pkg::result_t x_res;

    assign x_fire  = x_valid_reg && (!out_valid_reg || res_ready);
    assign q_ready = !x_valid_reg || x_fire;
    assign issue   = q_valid && q_ready;

    mse_ram #(
        .WIDTH(32),
        .DEPTH(mse_pkg::REG_COUNT)
    ) u_regfile (
        .clk     (clk),
        .we      (x_fire && x_wr),
        .waddr   (x_uop_reg.dest),
        .wdata   (x_val),
        .re      (issue),
        .raddr_a (q_uop.rs),
        .raddr_b (q_uop.rt),
        .rdata_a (ram_a),
        .rdata_b (ram_b)
    );

    // The RAM read is registered at the edge that loads the execute stage; the result written at that
    // same edge is forwarded, and never-written entries read as zero.
    always_comb
    begin
        x_valid_next = x_valid_reg;
        if (issue)
        begin
            x_valid_next = 1'b1;
        end
        else if (x_fire)
        begin
            x_valid_next = 1'b0;
        end
        a_byp_next   = x_fire && x_wr && (x_uop_reg.dest == q_uop.rs);
        b_byp_next   = x_fire && x_wr && (x_uop_reg.dest == q_uop.rt);
        written_next = written_reg;
        if (x_fire && x_wr)
        begin
            written_next[x_uop_reg.dest] = 1'b1;
        end
    end

    assign op_a = a_byp_reg ? byp_val_reg : (a_ok_reg ? ram_a : '0);
    assign op_b = b_byp_reg ? byp_val_reg : (b_ok_reg ? ram_b : '0);

    assign simm      = {{16{x_uop_reg.imm[15]}}, x_uop_reg.imm};
    assign pc_plus4  = pc_reg + 32'd4;
    assign ops_equal = (op_a == op_b);

    always_comb
    begin
        x_val     = '0;
        x_wr_kind = 1'b0;
        x_taken   = 1'b0;
        x_bad     = 1'b0;
        x_read    = 1'b0;
        unique case (x_uop_reg.kind)
            mse_pkg::UOP_READ:
            begin
                x_read = 1'b1;
            end
            mse_pkg::UOP_ADD:
            begin
                x_wr_kind = 1'b1;
                x_val     = op_a + op_b;
            end
            mse_pkg::UOP_ADDI:
            begin
                x_wr_kind = 1'b1;
                x_val     = op_a + simm;
            end
            mse_pkg::UOP_ANDI:
            begin
                x_wr_kind = 1'b1;
                x_val     = op_a & {16'h0000, x_uop_reg.imm};
            end
            mse_pkg::UOP_SLL:
            begin
                x_wr_kind = 1'b1;
                x_val     = op_b << x_uop_reg.shamt;
            end
            mse_pkg::UOP_SRL:
            begin
                x_wr_kind = 1'b1;
                x_val     = op_b >> x_uop_reg.shamt;
            end
            mse_pkg::UOP_BEQ: x_taken = ops_equal;
            mse_pkg::UOP_BNE: x_taken = !ops_equal;
            default:          x_bad   = 1'b1;
        endcase
        x_wr = x_wr_kind && (x_uop_reg.dest != '0);
    end

    always_comb
    begin
        if (x_read)
        begin
            x_npc = pc_reg;
        end
        else if (x_taken)
        begin
            x_npc = pc_plus4 + {simm[29:0], 2'b00};
        end
        else
        begin
            x_npc = pc_plus4;
        end
    end

    // Program window end, with the length clamped to the program store size.
    assign length_eff = (int'(length_reg) > int'(PROGRAM_WORDS)) ? LW'(PROGRAM_WORDS)
                                                                : length_reg;
    assign end_addr   = {1'b0, start_reg} + {{(33 - LW - 2){1'b0}}, length_eff, 2'b00};
    assign x_past     = (x_npc < start_reg) || ({1'b0, x_npc} >= end_addr);

    always_comb
    begin
        x_res.next_pc      = x_npc;
        x_res.reg_write    = x_wr;
        x_res.write_reg    = x_wr ? x_uop_reg.dest : '0;
        x_res.write_value  = x_wr ? x_val : '0;
        x_res.branch_taken = x_taken;
        x_res.illegal      = x_bad;
        x_res.past_end     = x_past;
        x_res.read_value   = x_read ? op_a : '0;
    end

    always_comb
    begin
        pc_next     = pc_reg;
        start_next  = start_reg;
        length_next = length_reg;
        if (cfg_write && (cfg_index == mse_pkg::CFG_START_ADDRESS))
        begin
            start_next = cfg_data;
            pc_next    = cfg_data;
        end
        else if (cfg_write && (cfg_index == mse_pkg::CFG_PROGRAM_LENGTH))
        begin
            length_next = cfg_data[LW-1:0];
        end
        else if (x_fire)
        begin
            pc_next = x_npc;
        end
        out_valid_next = out_valid_reg;
        if (x_fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (res_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_valid_reg   <= 1'b0;
            written_reg   <= '0;
            pc_reg        <= mse_pkg::RESET_PC;
            start_reg     <= mse_pkg::RESET_PC;
            length_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            x_valid_reg   <= x_valid_next;
            written_reg   <= written_next;
            pc_reg        <= pc_next;
            start_reg     <= start_next;
            length_reg    <= length_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            x_uop_reg   <= q_uop;
            a_byp_reg   <= a_byp_next;
            b_byp_reg   <= b_byp_next;
            a_ok_reg    <= written_reg[q_uop.rs[AW-1:0]];
            b_ok_reg    <= written_reg[q_uop.rt[AW-1:0]];
            byp_val_reg <= x_val;
        end
        if (x_fire)
        begin
            out_res_reg <= x_res;
        end
    end

    assign res_valid = out_valid_reg;
    assign res       = out_res_reg;

endmodule

// ===== design/mips_subset_executor_unit.sv =====
`timescale 1ns / 1ps
// Top level of the MIPS subset executor: front end, micro-op queue, back end.
// Depends on mse_pkg, mse_front, mse_queue, mse_back and mse_ram.

// The unit executes one MIPS instruction word (add, addi, andi, sll, srl, beq,
// bne) or returns one register per input beat, and produces exactly one result
// beat for each. It sustains one beat per clock while the consumer takes every
// result: the front end decodes a beat in the cycle it is accepted and places it
// in a small queue; the back end then reads the two-read-port register file,
// executes, and writes the register file and pc while loading the output
// register. A result written by one instruction is forwarded to the next so
// back-to-back dependent instructions still run at full rate. The register file
// reads as zero after reset through per-entry written flags, so no clearing pass
// is needed. Configuration writes (start_address, which also loads pc, and
// program_length) take effect at once and are expected only while the unit is
// idle. Unknown encodings only advance pc by four and are flagged illegal.
module mips_subset_executor_unit #(
    parameter int unsigned PROGRAM_WORDS = 256,
    parameter int unsigned QUEUE_DEPTH   = 2
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic                           action,
    input  logic [31:0]                    instr,
    input  logic [mse_pkg::REG_ADDR_W-1:0] reg_index,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [31:0]                    next_pc,
    output logic                           reg_write,
    output logic [mse_pkg::REG_ADDR_W-1:0] write_reg,
    output logic [31:0]                    write_value,
    output logic                           branch_taken,
    output logic                           illegal,
    output logic                           past_end,
    output logic [31:0]                    read_value,
    input  logic                           cfg_write,
    input  logic                           cfg_index,
    input  logic [31:0]                    cfg_data
);

    logic             push_valid;
    logic             push_ready;
    mse_pkg::uop_t    push_uop;
    logic             pop_valid;
    logic             pop_ready;
    mse_pkg::uop_t    pop_uop;
    mse_pkg::result_t res;

    // Front end: handshake and classification of each beat.
    mse_front u_front (
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .action     (action),
        .instr      (instr),
        .reg_index  (reg_index),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_uop   (push_uop)
    );

    // The queue lets the front end keep accepting while the back end is stalled
    // by the consumer, and the reverse.
    mse_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_uop   (push_uop),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_uop    (pop_uop)
    );

    // Back end: register file, pc, configuration, execute and output register.
    mse_back #(
        .PROGRAM_WORDS(PROGRAM_WORDS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (pop_valid),
        .q_ready   (pop_ready),
        .q_uop     (pop_uop),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .res_valid (out_valid),
        .res_ready (out_ready),
        .res       (res)
    );

    assign next_pc      = res.next_pc;
    assign reg_write    = res.reg_write;
    assign write_reg    = res.write_reg;
    assign write_value  = res.write_value;
    assign branch_taken = res.branch_taken;
    assign illegal      = res.illegal;
    assign past_end     = res.past_end;
    assign read_value   = res.read_value;

    // Register zero is never reported as written.
    a_no_zero_write: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && reg_write |-> write_reg != '0)
        else $error("register zero reported as written");

    // A taken branch or an illegal encoding never writes a register.
    a_branch_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (branch_taken || illegal) |-> !reg_write && write_value == '0)
        else $error("branch or illegal beat wrote a register");

    // A read beat with data carries no execute side effects.
    a_read_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && read_value != '0 |-> !reg_write && !branch_taken && !illegal)
        else $error("read beat shows execute side effects");

    // A queue beat offered but not taken means the back end holds a result the consumer has not taken.
    a_queue_stall: assert property (@(posedge clk) disable iff (!rst_n)
        pop_valid && !pop_ready |-> out_valid && !out_ready)
        else $error("back end stalled without a held result");

endmodule
